/* rtl/ssh_pkg.sv */
// shared types and constants for the sample statistics histogram block
`default_nettype none
package ssh_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int SUM_W       = 42;
    localparam int CNT_W       = 11;
    localparam int ADDR_W      = 10;
    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_BINS    = 32;
    localparam int BINS_W      = 6;
    localparam int BIN_IDX_W   = 5;
    localparam int CFG_RESET   = 10;
    localparam int DIV_NW      = 77;
    localparam int DIV_DW      = 33;
    localparam int DIV_CW      = 7;
    localparam int PROD_W      = 64;
    localparam int BNUM_W      = SAMPLE_W + BINS_W;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_BIN
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_MEAN_WAIT,
        S_SQ,
        S_VAR,
        S_VAR_WAIT,
        S_SQRT,
        S_SUMMARY,
        S_BIN_CLR,
        S_BIN_RD,
        S_BIN_DIV,
        S_BIN_WAIT,
        S_BIN_INC,
        S_BIN_OUT
    } t_state;

    typedef struct packed {
        logic     add;
        logic     rpt_init;
        logic     div_start;
        t_div_sel div_sel;
        logic     mean_take;
        logic     sq_run;
        logic     var_take;
        logic     sqrt_step;
        logic     load_summary;
        logic     bin_clear;
        logic     bin_read;
        logic     bin_inc;
        logic     load_bin;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic sq_done;
        logic sqrt_done;
        logic range_zero;
        logic idx_last;
        logic out_free;
        logic out_last;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/ssh_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module ssh_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [ssh_pkg::DIV_NW-1:0]    i_num,
    input  wire [ssh_pkg::DIV_DW-1:0]    i_den,
    input  wire [ssh_pkg::DIV_CW-1:0]    i_steps,
    output logic [ssh_pkg::DIV_NW-1:0]   o_quot,
    output logic                         o_done
);
    import ssh_pkg::*;

    logic                r_busy, r_done;
    logic [DIV_CW-1:0]   r_cnt;
    logic [DIV_NW-1:0]   r_num, r_quot;
    logic [DIV_DW-1:0]   r_rem, r_den;
    logic [DIV_DW:0]     trial;
    logic                fits;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NW-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NW-2:0], fits};
            r_rem  <= fits ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule
`default_nettype wire

/* rtl/ssh_ctrl.sv */
// controller state machine sequencing add and report requests
`default_nettype none
module ssh_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_opcode,
    output logic             o_in_ready,
    input  ssh_pkg::t_stat   i_stat,
    output ssh_pkg::t_cmd    o_cmd
);
    import ssh_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_opcode) begin
                        o_cmd.add = 1'b1;
                    end else begin
                        o_cmd.rpt_init = 1'b1;
                        n_state = i_stat.empty ? S_SUMMARY : S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN;
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                o_cmd.div_sel = DIV_MEAN;
                if (i_stat.div_done) begin
                    o_cmd.mean_take = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_run = 1'b1;
                if (i_stat.sq_done) begin
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
                n_state = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                o_cmd.div_sel = DIV_VAR;
                if (i_stat.div_done) begin
                    o_cmd.var_take = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_SUMMARY;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
            end
            S_SUMMARY: begin
                if (i_stat.out_free) begin
                    o_cmd.load_summary = 1'b1;
                    n_state = i_stat.empty ? S_IDLE : S_BIN_CLR;
                end
            end
            S_BIN_CLR: begin
                o_cmd.bin_clear = 1'b1;
                n_state = S_BIN_RD;
            end
            S_BIN_RD: begin
                o_cmd.bin_read = 1'b1;
                n_state = S_BIN_DIV;
            end
            S_BIN_DIV: begin
                o_cmd.div_sel = DIV_BIN;
                if (i_stat.range_zero) begin
                    n_state = S_BIN_INC;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_BIN_WAIT;
                end
            end
            S_BIN_WAIT: begin
                o_cmd.div_sel = DIV_BIN;
                if (i_stat.div_done) begin
                    n_state = S_BIN_INC;
                end
            end
            S_BIN_INC: begin
                o_cmd.div_sel = DIV_BIN;
                o_cmd.bin_inc = 1'b1;
                n_state = i_stat.idx_last ? S_BIN_OUT : S_BIN_RD;
            end
            S_BIN_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_bin = 1'b1;
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ssh_dp.sv */
// datapath: sample memory, running stats, deviation pass, root, histogram, output register
`default_nettype none
module ssh_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  ssh_pkg::t_cmd                      i_cmd,
    output ssh_pkg::t_stat                     o_stat,
    input  wire signed [ssh_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                i_cfg_valid,
    input  wire [ssh_pkg::BINS_W-1:0]          i_cfg_data,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_kind,
    output logic signed [ssh_pkg::SAMPLE_W-1:0] o_mean_value,
    output logic [ssh_pkg::SAMPLE_W-1:0]       o_std_dev,
    output logic [ssh_pkg::CNT_W-1:0]          o_sample_count,
    output logic                               o_overflow,
    output logic [ssh_pkg::BIN_IDX_W-1:0]      o_bin_index,
    output logic [ssh_pkg::CNT_W-1:0]          o_bin_hits,
    output logic                               o_last
);
    import ssh_pkg::*;

    // running state
    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_min, r_max;
    logic                       r_dropped;
    logic [BINS_W-1:0]          r_cfg, r_bins;
    logic                       full;

    assign full = r_count == CNT_W'(MAX_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_dropped <= 1'b0;
            r_cfg     <= BINS_W'(CFG_RESET);
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.add) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SUM_W'(i_sample);
                    if (r_count == '0 || i_sample < r_min) begin
                        r_min <= i_sample;
                    end
                    if (r_count == '0 || i_sample > r_max) begin
                        r_max <= i_sample;
                    end
                end
            end
        end
    end

    // effective bin count latched per report
    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_init) begin
            if (r_cfg == '0) begin
                r_bins <= BINS_W'(1);
            end else if (r_cfg > BINS_W'(MAX_BINS)) begin
                r_bins <= BINS_W'(MAX_BINS);
            end else begin
                r_bins <= r_cfg;
            end
        end
    end

    // sample memory, one write and one registered read
    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [CNT_W-1:0]    r_idx;
    logic                rd_en, wr_en, idx_more;

    assign idx_more = r_idx != r_count;
    assign wr_en    = i_cmd.add && !full;
    assign rd_en    = (i_cmd.sq_run && idx_more) || i_cmd.bin_read;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= i_sample;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    // shared divider
    logic [SUM_W-1:0]   sum_mag;
    logic               sum_neg;
    logic [DIV_NW-1:0]  div_num, div_quot, r_acc;
    logic [DIV_DW-1:0]  div_den;
    logic [DIV_CW-1:0]  div_steps;
    logic               div_done;
    logic [SAMPLE_W:0]  off_full, range_full;
    logic [SAMPLE_W-1:0] range_val;
    logic [BNUM_W-1:0]  bin_num;

    assign sum_neg    = r_sum[SUM_W-1];
    assign sum_mag    = sum_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign range_full = {r_max[SAMPLE_W-1], r_max} - {r_min[SAMPLE_W-1], r_min};
    assign range_val  = range_full[SAMPLE_W-1:0];
    assign off_full   = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_min[SAMPLE_W-1], r_min};
    assign bin_num    = BNUM_W'(off_full[SAMPLE_W-1:0]) * BNUM_W'(r_bins);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_num   = {sum_mag, (DIV_NW-SUM_W)'(0)};
                div_den   = DIV_DW'(r_count);
                div_steps = DIV_CW'(SUM_W);
            end
            DIV_VAR: begin
                div_num   = r_acc;
                div_den   = DIV_DW'(r_count);
                div_steps = DIV_CW'(DIV_NW);
            end
            DIV_BIN: begin
                div_num   = {bin_num, (DIV_NW-BNUM_W)'(0)};
                div_den   = DIV_DW'(range_val);
                div_steps = DIV_CW'(BNUM_W);
            end
            default: begin
                div_num   = '0;
                div_den   = DIV_DW'(1);
                div_steps = DIV_CW'(1);
            end
        endcase
    end

    ssh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    // truncated mean
    logic signed [SAMPLE_W-1:0] r_mean;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_take) begin
            r_mean <= sum_neg ? SAMPLE_W'(-div_quot[SAMPLE_W:0])
                              : SAMPLE_W'(div_quot[SAMPLE_W:0]);
        end
    end

    // deviation pass: read, magnitude, square, accumulate
    logic                r_v1, r_v2, r_v3;
    logic [SAMPLE_W-1:0] r_mag;
    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W:0]   diff;

    assign diff = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_mean[SAMPLE_W-1], r_mean};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sq_run && idx_more;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        r_prod <= PROD_W'(r_mag) * PROD_W'(r_mag);
        if (i_cmd.rpt_init) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + DIV_NW'(r_prod);
        end
    end

    // sample index shared by both passes
    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_init || i_cmd.bin_clear) begin
            r_idx <= '0;
        end else if ((i_cmd.sq_run && idx_more) || i_cmd.bin_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // integer square root, two bits of radicand per step
    logic [PROD_W-1:0] r_rad, r_root, r_bit, root_try;
    assign root_try = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.var_take) begin
            r_rad  <= div_quot[PROD_W-1:0];
            r_root <= '0;
            r_bit  <= PROD_W'(1) << (PROD_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_rad >= root_try) begin
                r_rad  <= r_rad - root_try;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // histogram counters, one read address
    logic [CNT_W-1:0]     r_hist [MAX_BINS];
    logic [BIN_IDX_W-1:0] r_out_idx, hist_addr, bin_sel;
    logic [CNT_W-1:0]     hist_rd;
    logic [BINS_W-1:0]    quot_b;

    assign quot_b  = div_quot[BINS_W-1:0];
    assign bin_sel = (range_val == '0) ? '0 :
                     (quot_b >= r_bins) ? BIN_IDX_W'(r_bins - 1'b1) : BIN_IDX_W'(quot_b);
    assign hist_addr = i_cmd.load_bin ? r_out_idx : bin_sel;
    assign hist_rd   = r_hist[hist_addr];

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_clear) begin
            for (int k = 0; k < MAX_BINS; k++) begin
                r_hist[k] <= '0;
            end
            r_out_idx <= '0;
        end else begin
            if (i_cmd.bin_inc) begin
                r_hist[hist_addr] <= hist_rd + 1'b1;
            end
            if (i_cmd.load_bin) begin
                r_out_idx <= r_out_idx + 1'b1;
            end
        end
    end

    // output register
    logic out_last_bin, empty;
    assign empty        = r_count == '0;
    assign out_last_bin = BINS_W'(r_out_idx) == r_bins - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_summary || i_cmd.load_bin) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_summary) begin
            o_kind         <= 1'b0;
            o_mean_value   <= empty ? '0 : r_mean;
            o_std_dev      <= empty ? '0 : r_root[SAMPLE_W-1:0];
            o_sample_count <= r_count;
            o_overflow     <= r_dropped;
            o_bin_index    <= '0;
            o_bin_hits     <= '0;
            o_last         <= empty;
        end else if (i_cmd.load_bin) begin
            o_kind         <= 1'b1;
            o_mean_value   <= '0;
            o_std_dev      <= '0;
            o_sample_count <= '0;
            o_overflow     <= 1'b0;
            o_bin_index    <= r_out_idx;
            o_bin_hits     <= hist_rd;
            o_last         <= out_last_bin;
        end
    end

    // status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.empty      = empty;
        o_stat.div_done   = div_done;
        o_stat.sq_done    = !idx_more && !r_v1 && !r_v2 && !r_v3;
        o_stat.sqrt_done  = r_bit == '0;
        o_stat.range_zero = range_val == '0;
        o_stat.idx_last   = r_idx == r_count - 1'b1;
        o_stat.out_free   = !o_out_valid || i_out_ready;
        o_stat.out_last   = out_last_bin;
    end

endmodule
`default_nettype wire

/* rtl/sample_statistics_histogram_core.sv */
// top level of the sample statistics and histogram block
//
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_ready     i_opcode, i_sample
// out      output     o_out_valid / i_out_ready   o_kind .. o_last
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_data (bin count)
//
// an add request does one memory write and the running updates
// a report runs the mean divide, the deviation pass over the n stored samples,
// the variance divide and the square root to the summary, then bins each sample
// through the shared serial divider (skipped when all samples are equal) and
// then sends one result per bin; n is the number of stored samples
// reset is synchronous, clears the count, sum, extremes and flag, and sets the bin count to 10
// a stalled output holds the controller until the output register frees
`default_nettype none
module sample_statistics_histogram_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_opcode,
    input  wire signed [ssh_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [ssh_pkg::BINS_W-1:0]          i_cfg_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_kind,
    output logic signed [ssh_pkg::SAMPLE_W-1:0] o_mean_value,
    output logic [ssh_pkg::SAMPLE_W-1:0]       o_std_dev,
    output logic [ssh_pkg::CNT_W-1:0]          o_sample_count,
    output logic                               o_overflow,
    output logic [ssh_pkg::BIN_IDX_W-1:0]      o_bin_index,
    output logic [ssh_pkg::CNT_W-1:0]          o_bin_hits,
    output logic                               o_last
);
    import ssh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // controller
    ssh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    ssh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_sample       (i_sample),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow),
        .o_bin_index    (o_bin_index),
        .o_bin_hits     (o_bin_hits),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

/* dv/tb_sample_statistics_histogram_core.sv */
// self-checking testbench for the sample statistics histogram core
`default_nettype none
module tb_sample_statistics_histogram_core;
    import ssh_pkg::*;

    localparam int HOLD_CYCLES = 4000;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int ITEM_TARGET = 430;

    typedef struct {
        bit                       kind;
        bit signed [SAMPLE_W-1:0] mean_value;
        bit [SAMPLE_W-1:0]        std_dev;
        bit [CNT_W-1:0]           sample_count;
        bit                       overflow;
        bit [BIN_IDX_W-1:0]       bin_index;
        bit [CNT_W-1:0]           bin_hits;
        bit                       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_opcode = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic i_cfg_valid = 1'b0;
    logic [BINS_W-1:0] i_cfg_data = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_cfg_ready, o_out_valid;
    logic o_kind, o_overflow, o_last;
    logic signed [SAMPLE_W-1:0] o_mean_value;
    logic [SAMPLE_W-1:0] o_std_dev;
    logic [CNT_W-1:0] o_sample_count, o_bin_hits;
    logic [BIN_IDX_W-1:0] o_bin_index;

    int errors = 0;
    longint cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    logic signed [SAMPLE_W-1:0] last_value = '0;

    sample_statistics_histogram_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_sample(i_sample),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_mean_value(o_mean_value), .o_std_dev(o_std_dev),
        .o_sample_count(o_sample_count), .o_overflow(o_overflow),
        .o_bin_index(o_bin_index), .o_bin_hits(o_bin_hits), .o_last(o_last)
    );

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    // statistics predictor and queue of expected report results
    class stats_scoreboard;
        int store[$];
        longint total;
        int lo_val, hi_val;
        bit dropped;
        bit [BINS_W-1:0] bin_reg;
        t_result pending_results[$];

        function new();
            total = 0; lo_val = 0; hi_val = 0; dropped = 0; bin_reg = BINS_W'(CFG_RESET);
        endfunction

        function void set_bins(bit [BINS_W-1:0] v);
            bin_reg = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void queue_result(t_result r);
            pending_results = {pending_results, r};
        endfunction

        function bit [31:0] floor_sqrt(bit [63:0] v);
            bit [31:0] r;
            bit [127:0] t;
            r = 0;
            for (int i = 31; i >= 0; i--) begin
                t = {96'd0, r | (32'd1 << i)};
                if (t * t <= {64'd0, v}) r = r | (32'd1 << i);
            end
            return r;
        endfunction

        // an accepted request: add updates state, report queues its results
        function void note_input(bit op, logic signed [SAMPLE_W-1:0] x);
            t_result r;
            longint mean;
            longint diff;
            bit [127:0] dev_sum;
            bit [63:0] mag, variance;
            bit [63:0] range, off, b;
            int nb, n;
            int hits[MAX_BINS];
            n = store.size();
            if (op == 1'b0) begin
                if (n >= MAX_SAMPLES) begin
                    dropped = 1'b1;
                    return;
                end
                store = {store, int'(x)};
                if (n == 0) begin
                    lo_val = x; hi_val = x;
                end else begin
                    if (x < lo_val) lo_val = x;
                    if (x > hi_val) hi_val = x;
                end
                total += longint'(x);
                return;
            end
            r = '{default: 0};
            r.sample_count = CNT_W'(n);
            r.overflow = dropped;
            if (n == 0) begin
                r.last = 1'b1;
                queue_result(r);
                return;
            end
            mean = total / n;
            dev_sum = 0;
            foreach (store[i]) begin
                diff = longint'(store[i]) - mean;
                mag = (diff < 0) ? -diff : diff;
                dev_sum += {64'd0, mag * mag};
            end
            variance = 64'(dev_sum / n);
            r.mean_value = mean[31:0];
            r.std_dev = floor_sqrt(variance);
            queue_result(r);
            nb = (bin_reg == 0) ? 1 : (bin_reg > MAX_BINS) ? MAX_BINS : int'(bin_reg);
            foreach (hits[i]) hits[i] = 0;
            range = longint'(hi_val) - longint'(lo_val);
            foreach (store[i]) begin
                b = 0;
                if (range != 0) begin
                    off = longint'(store[i]) - longint'(lo_val);
                    b = (off * nb) / range;
                    if (b >= nb) b = nb - 1;
                end
                hits[b]++;
            end
            for (int i = 0; i < nb; i++) begin
                r = '{default: 0};
                r.kind = 1'b1;
                r.bin_index = BIN_IDX_W'(i);
                r.bin_hits = CNT_W'(hits[i]);
                r.last = (i == nb - 1);
                queue_result(r);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", got.kind, -1);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
            if (got.mean_value != want.mean_value)
                report_mismatch("mean_value", got.mean_value, want.mean_value);
            if (got.std_dev != want.std_dev) report_mismatch("std_dev", got.std_dev, want.std_dev);
            if (got.sample_count != want.sample_count)
                report_mismatch("sample_count", got.sample_count, want.sample_count);
            if (got.overflow != want.overflow)
                report_mismatch("overflow", got.overflow, want.overflow);
            if (got.bin_index != want.bin_index)
                report_mismatch("bin_index", got.bin_index, want.bin_index);
            if (got.bin_hits != want.bin_hits)
                report_mismatch("bin_hits", got.bin_hits, want.bin_hits);
            if (got.last != want.last) report_mismatch("last", got.last, want.last);
        endtask
    endclass

    stats_scoreboard sb = new();

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sample_statistics_histogram_core: mismatch");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold on request
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // result monitor, sampled away from the active edge
    always @(negedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind = o_kind;
            got.mean_value = o_mean_value;
            got.std_dev = o_std_dev;
            got.sample_count = o_sample_count;
            got.overflow = o_overflow;
            got.bin_index = o_bin_index;
            got.bin_hits = o_bin_hits;
            got.last = o_last;
            sb.check_result(got);
        end
    end

    // offer one request, wait for acceptance, then maybe open a gap
    task automatic push_item(input bit op, input logic signed [SAMPLE_W-1:0] x);
        int gap;
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_sample <= x;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        sb.note_input(op, x);
        items_sent++;
        if (op == 1'b0) last_value = x;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all expected results, then let the controller settle
    task automatic wait_idle();
        stop_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_bins(input bit [BINS_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        sb.set_bins(v);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= BINS_W'($urandom);
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return last_value;
            3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty report, single sample, equal samples, extremes
        push_item(1'b1, 32'sh7fff_ffff);
        push_item(1'b0, 32'sh0001_8000);
        push_item(1'b1, 32'sh0);
        push_item(1'b0, 32'sh0001_8000);
        push_item(1'b0, 32'sh0001_8000);
        push_item(1'b1, 32'sh8000_0000);
        write_bins(6'd1);
        push_item(1'b0, 32'sh8000_0000);
        push_item(1'b0, 32'sh7fff_ffff);
        push_item(1'b1, 32'sh0);
        write_bins(6'd32);
        push_item(1'b0, 32'sh0);
        push_item(1'b0, -32'sh1);
        push_item(1'b0, 32'sh5555_5555);
        push_item(1'b0, -32'sh5555_5556);
        push_item(1'b1, 32'sh0);
        write_bins(6'd0);
        push_item(1'b1, 32'shffff_ffff);
        write_bins(6'd63);
        push_item(1'b1, 32'sh0);
        write_bins(6'd10);
        push_item(1'b1, 32'sh0);

        // random phases, each under a fresh bin count
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0: write_bins(6'd1);
                1: write_bins(6'd32);
                default: write_bins(BINS_W'($urandom));
            endcase
            if (!hold_req && items_sent > 200) begin
                // long receiver hold while requests keep coming
                hold_req <= 1'b1;
                push_item(1'b1, $urandom);
                for (int i = 0; i < 12; i++) push_item(1'($urandom_range(0, 1)), pick_sample());
            end
            k = $urandom_range(1, 25);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 11) == 0) push_item(1'b1, $urandom);
                else push_item(1'b0, pick_sample());
            end
            push_item(1'b1, $urandom);
        end

        // closing report with a single bin after a top-edge sample
        write_bins(6'd1);
        push_item(1'b0, 32'sh7fff_ffff);
        push_item(1'b1, $urandom);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && sb.pending() == 0) begin
            $display("sample_statistics_histogram_core: match");
        end else begin
            $display("sample_statistics_histogram_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
